FILE: rtl/core/bf_pkg.sv
// shared constants, types and codes for the phased array beamformer
package bf_pkg;

  localparam int BEAMS_MAX_DEF    = 8;
  localparam int ANTENNAS_MAX_DEF = 16;
  localparam int CHANNELS_DEF     = 64;

  localparam int SMP_W  = 16;
  localparam int WT_W   = 4 * SMP_W;
  localparam int PROD_W = 2 * SMP_W;
  localparam int CSUM_W = PROD_W + 1;
  localparam int ACC_W  = 37;
  localparam int OUT_W  = 39;
  localparam int RND_W  = CSUM_W + 1 - 15;
  localparam int POW_W  = 38;
  localparam int ROOT_W = POW_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int RCNT_W = $clog2(ROOT_W);

  // cycles from the last issue until the power accumulators have settled
  localparam int DRAIN_CYC = 4;
  localparam int DCNT_W    = $clog2(DRAIN_CYC);

  localparam logic [3:0] INC_BEAM = 4'd8;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTENNAS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAMS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_ROOT   = 3'd4;

  typedef struct packed {
    logic signed [SMP_W-1:0] yi;
    logic signed [SMP_W-1:0] yr;
    logic signed [SMP_W-1:0] xi;
    logic signed [SMP_W-1:0] xr;
  } sample_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] yi;
    logic signed [ACC_W-1:0] yr;
    logic signed [ACC_W-1:0] xi;
    logic signed [ACC_W-1:0] xr;
  } acc_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } cmac_ctl_t;

endpackage

FILE: rtl/core/bf_wmem.sv
// weight store: one write port, one registered read port
module bf_wmem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [bf_pkg::WT_W-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  input  logic                   rzero,
  output logic [bf_pkg::WT_W-1:0] rdata
);

  logic [bf_pkg::WT_W-1:0] mem [DEPTH];
  logic [bf_pkg::WT_W-1:0] rd_q;
  logic                    zero_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q   <= mem[raddr];
    zero_q <= rzero;
  end

  // channels beyond the store read as zero weights
  assign rdata = zero_q ? '0 : rd_q;

endmodule

FILE: rtl/core/bf_cmac.sv
// shared complex multiply-accumulate with beam accumulator memory and power path
module bf_cmac #(
  parameter int BEAMS_MAX = bf_pkg::BEAMS_MAX_DEF,
  parameter int BI_W      = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bf_pkg::cmac_ctl_t          ctl,
  input  logic [BI_W-1:0]            addr,
  input  bf_pkg::sample_t            smp,
  input  logic [bf_pkg::WT_W-1:0]    wt,
  output bf_pkg::acc_t               acc_out,
  output logic [bf_pkg::POW_W-1:0]   power_x,
  output logic [bf_pkg::POW_W-1:0]   power_y
);

  bf_pkg::acc_t mem [BEAMS_MAX];
  bf_pkg::acc_t rd_q;
  logic [BEAMS_MAX-1:0] used;
  logic used_q;

  bf_pkg::sample_t w;
  logic v1, v2, v3, v4;
  logic [BI_W-1:0] b1, b2;
  bf_pkg::acc_t acc2, acc_new;
  logic signed [bf_pkg::PROD_W-1:0] p_xr_a, p_xr_b, p_xi_a, p_xi_b;
  logic signed [bf_pkg::PROD_W-1:0] p_yr_a, p_yr_b, p_yi_a, p_yi_b;
  logic signed [bf_pkg::CSUM_W-1:0] cxr, cxi, cyr, cyi;
  logic signed [bf_pkg::RND_W-1:0] r_xr, r_xi, r_yr, r_yi;
  logic [bf_pkg::POW_W-1:0] sq_xr, sq_xi, sq_yr, sq_yi;

  assign w = wt;
  assign acc_out = used_q ? rd_q : '0;

  function automatic logic signed [bf_pkg::RND_W-1:0] round15(
    input logic signed [bf_pkg::CSUM_W-1:0] p
  );
    logic signed [bf_pkg::CSUM_W:0] t;
    t = {p[bf_pkg::CSUM_W-1], p} + (bf_pkg::CSUM_W+1)'(16384);
    return t[bf_pkg::CSUM_W:15];
  endfunction

  function automatic logic signed [bf_pkg::ACC_W-1:0] sext(
    input logic signed [bf_pkg::CSUM_W-1:0] p
  );
    return {{(bf_pkg::ACC_W-bf_pkg::CSUM_W){p[bf_pkg::CSUM_W-1]}}, p};
  endfunction

  always_comb begin
    cxr = {p_xr_a[bf_pkg::PROD_W-1], p_xr_a} - {p_xr_b[bf_pkg::PROD_W-1], p_xr_b};
    cxi = {p_xi_a[bf_pkg::PROD_W-1], p_xi_a} + {p_xi_b[bf_pkg::PROD_W-1], p_xi_b};
    cyr = {p_yr_a[bf_pkg::PROD_W-1], p_yr_a} - {p_yr_b[bf_pkg::PROD_W-1], p_yr_b};
    cyi = {p_yi_a[bf_pkg::PROD_W-1], p_yi_a} + {p_yi_b[bf_pkg::PROD_W-1], p_yi_b};
    acc_new.xr = acc2.xr + sext(cxr);
    acc_new.xi = acc2.xi + sext(cxi);
    acc_new.yr = acc2.yr + sext(cyr);
    acc_new.yi = acc2.yi + sext(cyi);
  end

  // accumulator memory, read at the issued beam, written back at the beam held in b2 while v2 is set
  always_ff @(posedge clk) begin
    rd_q <= mem[addr];
    if (v2) begin
      mem[b2] <= acc_new;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    b1     <= addr;
    p_xr_a <= smp.xr * w.xr;
    p_xr_b <= smp.xi * w.xi;
    p_xi_a <= smp.xr * w.xi;
    p_xi_b <= smp.xi * w.xr;
    p_yr_a <= smp.yr * w.yr;
    p_yr_b <= smp.yi * w.yi;
    p_yi_a <= smp.yr * w.yi;
    p_yi_b <= smp.yi * w.yr;
    b2     <= b1;
    acc2   <= acc_out;
    r_xr   <= round15(cxr);
    r_xi   <= round15(cxi);
    r_yr   <= round15(cyr);
    r_yi   <= round15(cyi);
    sq_xr  <= bf_pkg::POW_W'(r_xr * r_xr);
    sq_xi  <= bf_pkg::POW_W'(r_xi * r_xi);
    sq_yr  <= bf_pkg::POW_W'(r_yr * r_yr);
    sq_yi  <= bf_pkg::POW_W'(r_yi * r_yi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      used    <= '0;
      used_q  <= 1'b0;
      power_x <= '0;
      power_y <= '0;
    end else begin
      v1     <= ctl.issue;
      v2     <= v1;
      v3     <= v2 && (b2 == '0);
      v4     <= v3;
      used_q <= used[addr];
      if (ctl.clear) begin
        used    <= '0;
        power_x <= '0;
        power_y <= '0;
      end else begin
        if (v2) begin
          used[b2] <= 1'b1;
        end
        if (v4) begin
          power_x <= power_x + sq_xr + sq_xi;
          power_y <= power_y + sq_yr + sq_yi;
        end
      end
    end
  end

endmodule

FILE: rtl/core/bf_isqrt.sv
// iterative integer square root, one result bit per cycle
module bf_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bf_pkg::POW_W-1:0]  din,
  output logic [bf_pkg::ROOT_W-1:0] root,
  output logic                      busy,
  output logic                      done
);

  logic [bf_pkg::POW_W-1:0]  v;
  logic [bf_pkg::REM_W-1:0]  rem, rem_sh, trial;
  logic [bf_pkg::RCNT_W-1:0] cnt;

  always_comb begin
    rem_sh = {rem[bf_pkg::REM_W-3:0], v[bf_pkg::POW_W-1 -: 2]};
    trial  = {{(bf_pkg::REM_W-bf_pkg::ROOT_W-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= din;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v <= {v[bf_pkg::POW_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[bf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[bf_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bf_pkg::RCNT_W'(bf_pkg::ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/phased_array_beamformer_top.sv
// phased array beamformer top level: sequencer, config registers, output register
//
//  channel  | direction | contents
//  s_*      | in        | tuser: mode; tdata: beam, antenna, channel, x_re, x_im, y_re, y_im
//  m_*      | out       | tdata: beam_out, sum_x_re, sum_x_im, sum_y_re, sum_y_im; tlast: last
//  cfg_*    | in        | register index and data, written when cfg_we is high
//
//  a load transaction leaves the sequencer idle; the weight store write port takes it at once
//  a sample transaction issues each active beam, one per cycle, through the shared complex
//  multiply-accumulate, then waits in the drain state for its pipeline to settle
//  on the last antenna each beam result goes through the read, read-wait and output states and
//  waits out any output stall; the incoherent root adds two passes of the bit-serial square root unit
//  s_tready is high only while the sequencer is idle; reset clears all accumulators
module phased_array_beamformer_top #(
  parameter int BEAMS_MAX    = bf_pkg::BEAMS_MAX_DEF,
  parameter int ANTENNAS_MAX = bf_pkg::ANTENNAS_MAX_DEF,
  parameter int CHANNELS     = bf_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [79:0]                    s_tdata,  // beam, antenna, channel, x_re, x_im, y_re, y_im
  input  logic                           s_tuser,  // mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [159:0]                   m_tdata,  // beam_out, sum_x_re, sum_x_im, sum_y_re, sum_y_im
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [bf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NA_W  = ($clog2(ANTENNAS_MAX + 1) > 5) ? $clog2(ANTENNAS_MAX + 1) : 5;
  localparam int NB_W  = ($clog2(BEAMS_MAX + 1) > 4) ? $clog2(BEAMS_MAX + 1) : 4;
  localparam int BI_W  = (BEAMS_MAX > 1) ? $clog2(BEAMS_MAX) : 1;
  localparam int DEPTH = BEAMS_MAX * ANTENNAS_MAX * CHANNELS;
  localparam int WA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MAC   = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_RD    = 8'b0000_1000,
    ST_RDW   = 8'b0001_0000,
    ST_OUT   = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_INCO  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [4:0] ants_reg;
  logic [3:0] beams_reg;
  logic       fmt_reg, inc_en_reg, inc_root_reg;

  // input unpacking
  logic [2:0]      in_beam;
  logic [3:0]      in_ant;
  logic [5:0]      in_ch;
  bf_pkg::sample_t in_val, smp_dec;
  logic            s_fire, m_fire;

  // sample held while the beams are worked
  bf_pkg::sample_t smp_q;
  logic [3:0]      ant_q;
  logic [5:0]      ch_q;
  logic            last_ant_q;

  logic [NA_W-1:0]   na;
  logic [NB_W-1:0]   nb;
  logic [BI_W-1:0]   cnt;
  logic              cnt_last;
  logic [bf_pkg::DCNT_W-1:0] dcnt;

  // weight store hookup
  logic            w_we, w_rzero;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [bf_pkg::WT_W-1:0] w_rdata;

  // shared multiply-accumulate hookup
  bf_pkg::cmac_ctl_t ctl;
  bf_pkg::acc_t      acc_rd;
  logic [bf_pkg::POW_W-1:0] pow_x, pow_y;

  // square root hookup
  logic                      sq_start, sq_phase, sq_busy, sq_done;
  logic [bf_pkg::ROOT_W-1:0] sq_root, root_x;

  // output register
  logic [3:0]                     o_beam;
  logic signed [bf_pkg::OUT_W-1:0] o_xr, o_xi, o_yr, o_yi;
  logic                           o_last;

  assign in_beam = s_tdata[2:0];
  assign in_ant  = s_tdata[6:3];
  assign in_ch   = s_tdata[12:7];
  assign in_val  = s_tdata[76:13];

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_OUT) || (state == ST_INCO);
  assign m_fire   = m_tvalid && m_tready;
  assign m_tdata  = {o_yi, o_yr, o_xi, o_xr, o_beam};
  assign m_tlast  = o_last;

  // register values out of range clamp to the legal span
  always_comb begin
    if (ants_reg == '0) begin
      na = NA_W'(1);
    end else if (NA_W'(ants_reg) > NA_W'(ANTENNAS_MAX)) begin
      na = NA_W'(ANTENNAS_MAX);
    end else begin
      na = NA_W'(ants_reg);
    end
    if (beams_reg == '0) begin
      nb = NB_W'(1);
    end else if (NB_W'(beams_reg) > NB_W'(BEAMS_MAX)) begin
      nb = NB_W'(BEAMS_MAX);
    end else begin
      nb = NB_W'(beams_reg);
    end
  end

  assign cnt_last = (NB_W'(cnt) == nb - NB_W'(1));

  // 8-bit samples live in the low byte and are scaled up to Q1.15
  function automatic logic signed [bf_pkg::SMP_W-1:0] dec(
    input logic signed [bf_pkg::SMP_W-1:0] v, input logic q15
  );
    return q15 ? v : {v[7:0], 8'h00};
  endfunction

  always_comb begin
    smp_dec.xr = dec(in_val.xr, fmt_reg);
    smp_dec.xi = dec(in_val.xi, fmt_reg);
    smp_dec.yr = dec(in_val.yr, fmt_reg);
    smp_dec.yi = dec(in_val.yi, fmt_reg);
  end

  // weight store addressing: beam-major, then antenna, then channel
  always_comb begin
    w_we = s_fire && (s_tuser == bf_pkg::MODE_LOAD) && (int'(in_beam) < BEAMS_MAX)
           && (int'(in_ant) < ANTENNAS_MAX) && (int'(in_ch) < CHANNELS);
    w_waddr = WA_W'((int'(in_beam) * ANTENNAS_MAX + int'(in_ant)) * CHANNELS + int'(in_ch));
    w_raddr = WA_W'((int'(cnt) * ANTENNAS_MAX + int'(ant_q)) * CHANNELS + int'(ch_q));
    w_rzero = (int'(ch_q) >= CHANNELS);
  end

  always_comb begin
    ctl.issue = (state == ST_MAC);
    ctl.clear = m_fire && o_last;
  end

  bf_wmem #(
    .DEPTH(DEPTH),
    .AW   (WA_W)
  ) u_wmem (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(in_val),
    .raddr(w_raddr),
    .rzero(w_rzero),
    .rdata(w_rdata)
  );

  bf_cmac #(
    .BEAMS_MAX(BEAMS_MAX),
    .BI_W     (BI_W)
  ) u_cmac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .addr   (cnt),
    .smp    (smp_q),
    .wt     (w_rdata),
    .acc_out(acc_rd),
    .power_x(pow_x),
    .power_y(pow_y)
  );

  bf_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .din  (sq_phase ? pow_y : pow_x),
    .root (sq_root),
    .busy (sq_busy),
    .done (sq_done)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire && (s_tuser == bf_pkg::MODE_SAMPLE) && (NA_W'(in_ant) < na)) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dcnt == '0) begin
          state_next = last_ant_q ? ST_RD : ST_IDLE;
        end
      end
      ST_RD:   state_next = ST_RDW;
      ST_RDW:  state_next = ST_OUT;
      ST_OUT: begin
        if (m_fire) begin
          priority if (!cnt_last) begin
            state_next = ST_RD;
          end else if (!inc_en_reg) begin
            state_next = ST_IDLE;
          end else if (inc_root_reg) begin
            state_next = ST_SQRT;
          end else begin
            state_next = ST_INCO;
          end
        end
      end
      ST_SQRT: begin
        if (sq_done && sq_phase) begin
          state_next = ST_INCO;
        end
      end
      ST_INCO: begin
        if (m_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      dcnt         <= '0;
      sq_start     <= 1'b0;
      sq_phase     <= 1'b0;
      ants_reg     <= 5'd16;
      beams_reg    <= 4'd8;
      fmt_reg      <= 1'b0;
      inc_en_reg   <= 1'b0;
      inc_root_reg <= 1'b0;
    end else begin
      state    <= state_next;
      sq_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          bf_pkg::CFG_ANTENNAS:   ants_reg     <= cfg_data[4:0];
          bf_pkg::CFG_BEAMS:      beams_reg    <= cfg_data[3:0];
          bf_pkg::CFG_FORMAT:     fmt_reg      <= cfg_data[0];
          bf_pkg::CFG_INC_ENABLE: inc_en_reg   <= cfg_data[0];
          bf_pkg::CFG_INC_ROOT:   inc_root_reg <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: cnt <= '0;
        ST_MAC: begin
          if (cnt_last) begin
            cnt  <= '0;
            dcnt <= bf_pkg::DCNT_W'(bf_pkg::DRAIN_CYC - 1);
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: dcnt <= dcnt - 1'b1;
        ST_OUT: begin
          if (m_fire) begin
            if (!cnt_last) begin
              cnt <= cnt + 1'b1;
            end else if (inc_en_reg && inc_root_reg) begin
              // first pass on the x power
              sq_start <= 1'b1;
              sq_phase <= 1'b0;
            end
          end
        end
        ST_SQRT: begin
          if (sq_done && !sq_phase) begin
            sq_start <= 1'b1;
            sq_phase <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // sample capture and output register, payload only
  always_ff @(posedge clk) begin
    if (s_fire) begin
      smp_q      <= smp_dec;
      ant_q      <= in_ant;
      ch_q       <= in_ch;
      last_ant_q <= (NA_W'(in_ant) == na - NA_W'(1));
    end
    if (state == ST_SQRT && sq_done && !sq_phase) begin
      root_x <= sq_root;
    end
    if (state == ST_RDW) begin
      o_beam <= 4'(cnt);
      o_xr   <= bf_pkg::OUT_W'(acc_rd.xr);
      o_xi   <= bf_pkg::OUT_W'(acc_rd.xi);
      o_yr   <= bf_pkg::OUT_W'(acc_rd.yr);
      o_yi   <= bf_pkg::OUT_W'(acc_rd.yi);
      o_last <= !inc_en_reg && cnt_last;
    end else if ((state == ST_OUT && m_fire && cnt_last && inc_en_reg && !inc_root_reg)
                 || (state == ST_SQRT && sq_done && sq_phase)) begin
      // incoherent power beam
      o_beam <= bf_pkg::INC_BEAM;
      o_xr   <= inc_root_reg ? bf_pkg::OUT_W'(root_x) : bf_pkg::OUT_W'(pow_x);
      o_xi   <= '0;
      o_yr   <= inc_root_reg ? bf_pkg::OUT_W'(sq_root) : bf_pkg::OUT_W'(pow_y);
      o_yi   <= '0;
      o_last <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst) (state == ST_MAC) |-> (NB_W'(cnt) < nb))
    else $error("beam counter beyond active beams");

  assert property (@(posedge clk) disable iff (rst) sq_busy |-> (state == ST_SQRT))
    else $error("square root running outside its phase");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (o_beam == bf_pkg::INC_BEAM)) |-> m_tlast)
    else $error("incoherent beam not marked last");

  assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_tuser == bf_pkg::MODE_LOAD)) |=> (state == ST_IDLE))
    else $error("load transaction left the idle state");

endmodule
